/* design/ppcrel_pkg.sv */
// ----------------------------------------------------------------------------
// ppcrel_pkg
// Shared types and constants for the PowerPC relocation patcher: record
// opcodes, patch kinds, status codes and the structs between its modules.
// ----------------------------------------------------------------------------
package ppcrel_pkg;

  localparam int SECTIONS = 32;
  localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam logic [8:0] SEC_LIMIT = 9'(SECTIONS);

  localparam logic [31:0] HA_ROUND_BIT = 32'h0000_8000;
  localparam logic [31:0] HA_CARRY = 32'h0001_0000;
  localparam logic [31:0] HALF_MASK = 32'h0000_FFFF;
  localparam logic [31:0] REL24_KEEP = 32'hFC00_0003;
  localparam logic [31:0] REL24_FIELD = 32'h03FF_FFFC;

  typedef enum logic [3:0] {
    OP_LOAD_BASE = 4'd0,
    OP_END = 4'd1,
    OP_SECTION = 4'd2,
    OP_NOP = 4'd3,
    OP_ADDR32 = 4'd4,
    OP_ADDR16_LO = 4'd5,
    OP_ADDR16_HA = 4'd6,
    OP_REL24 = 4'd7,
    OP_UNSUPPORTED = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    K_ADDR32 = 2'd0,
    K_ADDR16_LO = 2'd1,
    K_ADDR16_HA = 2'd2,
    K_REL24 = 2'd3
  } kind_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_PATCH_UNMAPPED = 2'd1;
  localparam logic [1:0] ST_SYM_UNMAPPED = 2'd2;

  typedef struct packed {
    kind_t kind;
    logic [31:0] offset;
    logic [31:0] addend;
  } rec_t;

  typedef struct packed {
    logic [31:0] base_c;
    logic map_c;
    logic [31:0] base_t;
    logic map_t;
  } rd_t;

endpackage

/* design/ppc_relocation_patcher.sv */
// ----------------------------------------------------------------------------
// ppc_relocation_patcher
// Applies a stream of self-relocation records and emits one patch command
// for each ADDR32, ADDR16_LO, ADDR16_HA or REL24 record.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_stall   op, offset_delta, target_section, addend,
//                                  base_value, base_mapped
//   output   out_valid / out_stall patch_address, patch_data, patch_size,
//                                  keep_mask, status
//
// One record is accepted per cycle while in_stall is low. A patch passes through
// the table read, the address sums, then field select into the result register.
// Reset clears the cursor and all mapped flags.
// An output stall holds the result and backs up the pipeline stage by stage.
// ----------------------------------------------------------------------------
module ppc_relocation_patcher (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [3:0] op,
  input  logic [15:0] offset_delta,
  input  logic [7:0] target_section,
  input  logic [31:0] addend,
  input  logic [31:0] base_value,
  input  logic base_mapped,
  output logic out_valid,
  input  logic out_stall,
  output logic [31:0] patch_address,
  output logic [31:0] patch_data,
  output logic patch_size,
  output logic [31:0] keep_mask,
  output logic [1:0] status
);
  import ppcrel_pkg::*;

  logic [7:0] cursor_section;
  logic [31:0] cursor_offset;
  logic [31:0] offset_sum;
  logic accept;
  logic is_patch;
  logic s1_en;
  logic s1_ready;
  logic s1_valid;
  rec_t s1;
  rd_t rd;
  kind_t kind_in;
  logic table_we;

  assign s1_en = !s1_valid || s1_ready;
  assign in_stall = !s1_en;
  assign accept = in_valid && s1_en;
  assign offset_sum = cursor_offset + {16'd0, offset_delta};
  assign is_patch = (op == OP_ADDR32) || (op == OP_ADDR16_LO) ||
                    (op == OP_ADDR16_HA) || (op == OP_REL24);
  assign kind_in = kind_t'(op[1:0]);
  assign table_we = accept && (op == OP_LOAD_BASE) &&
                    ({1'b0, target_section} < SEC_LIMIT);

  ppcrel_table u_table (
    .clk(clk),
    .rst(rst),
    .we(table_we),
    .wr_sec(target_section),
    .wr_base(base_value),
    .wr_mapped(base_mapped),
    .rd_en(accept && is_patch),
    .rd_sec_c(cursor_section),
    .rd_sec_t(target_section),
    .rd(rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_section <= '0;
      cursor_offset <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid <= accept && is_patch;
      end
      if (accept) begin
        if (op == OP_END) begin
          cursor_section <= '0;
          cursor_offset <= '0;
        end else if (op == OP_SECTION) begin
          cursor_section <= target_section;
          cursor_offset <= '0;
        end else if (op != OP_LOAD_BASE) begin
          cursor_offset <= offset_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_patch) begin
      s1.kind <= kind_in;
      s1.offset <= offset_sum;
      s1.addend <= addend;
    end
  end

  ppcrel_compute u_compute (
    .clk(clk),
    .rst(rst),
    .s1_valid(s1_valid),
    .s1(s1),
    .rd(rd),
    .s1_ready(s1_ready),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .patch_address(patch_address),
    .patch_data(patch_data),
    .patch_size(patch_size),
    .keep_mask(keep_mask),
    .status(status)
  );

endmodule

/* design/ppcrel_table.sv */
// ----------------------------------------------------------------------------
// ppcrel_table
// Section load address memory with one write port and two registered read
// ports, plus per-section mapped flags that reset clears.
// ----------------------------------------------------------------------------
module ppcrel_table (
  input  logic clk,
  input  logic rst,
  input  logic we,
  input  logic [7:0] wr_sec,
  input  logic [31:0] wr_base,
  input  logic wr_mapped,
  input  logic rd_en,
  input  logic [7:0] rd_sec_c,
  input  logic [7:0] rd_sec_t,
  output ppcrel_pkg::rd_t rd
);
  import ppcrel_pkg::*;

  logic [31:0] base_mem [SECTIONS];
  logic [SECTIONS-1:0] mapped;
  logic in_range_c;
  logic in_range_t;

  assign in_range_c = {1'b0, rd_sec_c} < SEC_LIMIT;
  assign in_range_t = {1'b0, rd_sec_t} < SEC_LIMIT;

  always_ff @(posedge clk) begin
    if (we) begin
      base_mem[wr_sec[SEC_W-1:0]] <= wr_base;
    end
    if (rd_en) begin
      rd.base_c <= base_mem[rd_sec_c[SEC_W-1:0]];
      rd.base_t <= base_mem[rd_sec_t[SEC_W-1:0]];
    end
    if (rst) begin
      mapped <= '0;
      rd.map_c <= 1'b0;
      rd.map_t <= 1'b0;
    end else begin
      if (we) begin
        mapped[wr_sec[SEC_W-1:0]] <= wr_mapped;
      end
      if (rd_en) begin
        rd.map_c <= in_range_c && mapped[rd_sec_c[SEC_W-1:0]];
        rd.map_t <= in_range_t && mapped[rd_sec_t[SEC_W-1:0]];
      end
    end
  end

endmodule

/* design/ppcrel_compute.sv */
// ----------------------------------------------------------------------------
// ppcrel_compute
// Address stage and field stage of the patcher, ending in the result
// register that drives the output channel.
// ----------------------------------------------------------------------------
module ppcrel_compute (
  input  logic clk,
  input  logic rst,
  input  logic s1_valid,
  input  ppcrel_pkg::rec_t s1,
  input  ppcrel_pkg::rd_t rd,
  output logic s1_ready,
  output logic out_valid,
  input  logic out_stall,
  output logic [31:0] patch_address,
  output logic [31:0] patch_data,
  output logic patch_size,
  output logic [31:0] keep_mask,
  output logic [1:0] status
);
  import ppcrel_pkg::*;

  logic s2_valid;
  kind_t s2_kind;
  logic [1:0] s2_status;
  logic [31:0] s2_where;
  logic [31:0] s2_sym;
  logic out_en;
  logic s2_en;
  logic [31:0] ha_sum;
  logic [31:0] rel_diff;
  logic [31:0] data_next;
  logic size_next;
  logic [31:0] keep_next;

  assign out_en = !out_valid || !out_stall;
  assign s2_en = !s2_valid || out_en;
  assign s1_ready = s2_en;

  assign ha_sum = s2_sym + (s2_sym[15] ? HA_CARRY : 32'd0);
  assign rel_diff = s2_sym - s2_where;

  always_comb begin
    data_next = '0;
    size_next = 1'b0;
    keep_next = '0;
    unique case (s2_kind)
      K_ADDR32: begin
        data_next = s2_sym;
        size_next = 1'b1;
      end
      K_ADDR16_LO: begin
        data_next = s2_sym & HALF_MASK;
      end
      K_ADDR16_HA: begin
        data_next = {16'd0, ha_sum[31:16]};
      end
      K_REL24: begin
        data_next = rel_diff & REL24_FIELD;
        size_next = 1'b1;
        keep_next = REL24_KEEP;
      end
      default: begin
        data_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s2_en) begin
        s2_valid <= s1_valid;
      end
      if (out_en) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_valid) begin
      s2_kind <= s1.kind;
      s2_where <= rd.base_c + s1.offset;
      s2_sym <= rd.base_t + s1.addend;
      if (!rd.map_c) begin
        s2_status <= ST_PATCH_UNMAPPED;
      end else if (!rd.map_t) begin
        s2_status <= ST_SYM_UNMAPPED;
      end else begin
        s2_status <= ST_OK;
      end
    end
    if (out_en && s2_valid) begin
      status <= s2_status;
      if (s2_status == ST_OK) begin
        patch_address <= s2_where;
        patch_data <= data_next;
        patch_size <= size_next;
        keep_mask <= keep_next;
      end else begin
        patch_address <= '0;
        patch_data <= '0;
        patch_size <= 1'b0;
        keep_mask <= '0;
      end
    end
  end

endmodule
